// ----- rtl/u8d_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Shared widths, result record and lead byte classification.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int unsigned CpW      = 31;
  localparam int unsigned RemW     = 3;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW = $clog2(FifoDepth);
  localparam int unsigned FifoCntW = $clog2(FifoDepth + 1);

  localparam logic [CpW-1:0] ReplCp = CpW'(32'h0000_FFFD);

  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           repl;
    logic           last;
  } res_t;

  // Continuation bytes a lead byte announces; zero for anything not a lead.
  function automatic logic [RemW-1:0] tail_of(input logic [7:0] b);
    logic [RemW-1:0] t;
    t = '0;
    case (b) inside
      [8'hC0:8'hDF]: t = 3'd1;
      [8'hE0:8'hEF]: t = 3'd2;
      [8'hF0:8'hF7]: t = 3'd3;
      [8'hF8:8'hFB]: t = 3'd4;
      [8'hFC:8'hFD]: t = 3'd5;
      default:       t = 3'd0;
    endcase
    return t;
  endfunction

endpackage

// ----- rtl/u8d_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decode step
// Holds the open sequence state and turns one byte into up to two results.
// ----------------------------------------------------------------------------
module u8d_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          byte_i,
  output logic [1:0]          n_o,
  output u8d_pkg::res_t       r0_o,
  output u8d_pkg::res_t       r1_o
);
  import u8d_pkg::*;

  logic [CpW-1:0]  pv_q, pv_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic [RemW-1:0] tail;
  logic [5:0]      mask;
  logic            cont;
  logic            fresh_emit;
  res_t            fresh;

  assign tail = tail_of(byte_i);
  assign mask = 6'h3F >> tail;
  assign cont = (byte_i[7:6] == 2'b10);

  // Fresh decode: non-NUL ASCII passes; stray cont. byte, 0xFE/0xFF: U+FFFD.
  assign fresh_emit = (byte_i != 8'h00) && (!byte_i[7] || (tail == '0));
  assign fresh.cp   = byte_i[7] ? ReplCp : CpW'(byte_i);
  assign fresh.repl = byte_i[7];
  assign fresh.last = 1'b1;

  always_comb begin
    pv_d  = pv_q;
    rem_d = rem_q;
    r0_o  = '0;
    r1_o  = '0;
    n_o   = 2'd0;
    if ((rem_q != '0) && cont) begin
      pv_d  = {pv_q[CpW-7:0], byte_i[5:0]};
      rem_d = rem_q - RemW'(1);
      if (rem_q == RemW'(1)) begin
        r0_o = '{cp: pv_d, repl: 1'b0, last: 1'b1};
        n_o  = 2'd1;
      end
    end else begin
      if (rem_q != '0) begin
        // broken sequence
        r0_o  = '{cp: ReplCp, repl: 1'b1, last: 1'b1};
        n_o   = 2'd1;
        rem_d = '0;
        pv_d  = '0;
      end
      if ((byte_i != 8'h00) && (tail != '0)) begin
        pv_d  = CpW'(byte_i[5:0] & mask);
        rem_d = tail;
      end
      if (fresh_emit) begin
        if (n_o == 2'd1) begin
          r0_o.last = 1'b0;
          r1_o      = fresh;
          n_o       = 2'd2;
        end else begin
          r0_o = fresh;
          n_o  = 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= '0;
      rem_q <= '0;
    end else if (fire_i) begin
      pv_q  <= pv_d;
      rem_q <= rem_d;
    end
  end

endmodule

// ----- rtl/u8d_out_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder result queue
// Small queue taking up to two results a cycle and handing out one.
// ----------------------------------------------------------------------------
module u8d_out_fifo (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [1:0]                     push_n_i,
  input  u8d_pkg::res_t                  push0_i,
  input  u8d_pkg::res_t                  push1_i,
  input  logic                           pop_i,
  output logic                           room2_o,
  output logic                           not_empty_o,
  output u8d_pkg::res_t                  head_o,
  output logic [u8d_pkg::FifoCntW-1:0]   cnt_o
);
  import u8d_pkg::*;

  res_t                mem [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic [FifoPtrW-1:0] wr_next;

  assign wr_next     = wr_q + FifoPtrW'(1);
  assign room2_o     = (cnt_q <= FifoCntW'(FifoDepth - 2));
  assign not_empty_o = (cnt_q != '0);
  assign head_o      = mem[rd_q];
  assign cnt_o       = cnt_q;

  always_comb begin
    wr_d  = wr_q + FifoPtrW'(push_n_i);
    rd_d  = pop_i ? rd_q + FifoPtrW'(1) : rd_q;
    cnt_d = cnt_q + FifoCntW'(push_n_i) - FifoCntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem[wr_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      mem[wr_next] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- rtl/utf8_stream_decoder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream decoder core
// Decodes a UTF-8 byte stream into code points, one byte per unstalled cycle.
// ----------------------------------------------------------------------------
// Input channel: one byte per request (in_valid_i / in_stall_o / byte_in_i).
// Output channel: one code point per request (out_valid_o / out_stall_i),
// with is_replacement_o for U+FFFD on malformed input and last_of_run_o
// on the last result a byte produced. A byte yields zero, one or two results.
// Path: a byte is registered, then decoded into a four entry result queue,
// and shows at the output from the head of the queue.
// Throughput: one byte per cycle while the receiver keeps up; the second
// result of a byte that yields two is absorbed by the queue.
// The decode step needs two free queue slots, so the input stalls whenever
// a byte is waiting and the queue holds three or more results.
// Reset clears the open sequence, the input valid flag and the queue; no
// result is pending after reset. A stalled result holds its value.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [7:0]              byte_in_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [u8d_pkg::CpW-1:0] code_point_o,
  output logic                    is_replacement_o,
  output logic                    last_of_run_o
);
  import u8d_pkg::*;

  logic                vld_q, vld_d;
  logic [7:0]          byte_q;
  logic                room2;
  logic                fire;
  logic                pop;
  logic                not_empty;
  logic [1:0]          n;
  logic [1:0]          push_n;
  res_t                r0, r1, head;
  logic [FifoCntW-1:0] cnt;

  assign fire       = vld_q && room2;
  assign in_stall_o = vld_q && !room2;
  assign vld_d      = in_valid_i || in_stall_o;
  assign push_n     = fire ? n : 2'd0;
  assign pop        = not_empty && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      byte_q <= byte_in_i;
    end
  end

  u8d_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (byte_q),
    .n_o    (n),
    .r0_o   (r0),
    .r1_o   (r1)
  );

  u8d_out_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (push_n),
    .push0_i     (r0),
    .push1_i     (r1),
    .pop_i       (pop),
    .room2_o     (room2),
    .not_empty_o (not_empty),
    .head_o      (head),
    .cnt_o       (cnt)
  );

  assign out_valid_o      = not_empty;
  assign code_point_o     = head.cp;
  assign is_replacement_o = head.repl;
  assign last_of_run_o    = head.last;

  // queue never overfills
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt <= FifoCntW'(FifoDepth))
    else $error("result queue overflow");

  // a replacement always carries U+FFFD
  a_repl_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_replacement_o) |-> (code_point_o == ReplCp))
    else $error("replacement with wrong code point");

  // both results of a byte are queued together, so the second follows at once
  a_run_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_of_run_o) |=> out_valid_o)
    else $error("second result of a byte missing");

  // decode only fires with two free slots
  a_fire_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (n == 2'd2)) |-> (cnt <= FifoCntW'(FifoDepth - 2)))
    else $error("double push without room");

endmodule
